// ===== rtl/core/pixel_offset_to_distance_poly_assert.svh =====
// assertion macros used by the core top-level file
`ifndef PIXEL_OFFSET_TO_DISTANCE_POLY_ASSERT_SVH
`define PIXEL_OFFSET_TO_DISTANCE_POLY_ASSERT_SVH

// same-cycle implication, disabled during reset
`define POD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define POD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/pod_pkg.sv =====
`timescale 1ns / 1ps

package pod_pkg;

    // lane pipeline depth, from lane input register to lane result register
    localparam int LANE_LAT = 8;

    localparam int DIST_W = 17;
    localparam int OFFS_W = 18;
    localparam int LIMIT_W = 16;
    localparam int CFG_IDX_W = 3;

    // saturated product width: magnitudes are capped at 2^61
    localparam int SAT_W = 62;
    localparam int Q_SHIFT = 16;
    localparam int ROUND_SHIFT = 24;

    localparam logic [CFG_IDX_W-1:0] IDX_X_LIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_X_CUBIC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_X_QUINTIC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_Y_LIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_Y_CUBIC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_Y_QUINTIC = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_LIMIT = 3'd6;

    localparam int X_LIN_RST = 2792514;
    localparam int X_CUBIC_RST = 1197336;
    localparam int X_QUINTIC_RST = -109825;
    localparam int Y_LIN_RST = 4909484;
    localparam int Y_CUBIC_RST = -777111;
    localparam int Y_QUINTIC_RST = 713187;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd51200;

    typedef struct packed {
        logic vld;
        logic lamp_ok;
        logic center_ok;
    } flag_t;

endpackage

// ===== rtl/core/pixel_offset_to_distance_poly.sv =====
`timescale 1ns / 1ps
// channel | handshake              | payload
// in      | in_valid / in_ready     | lamp_valid lamp_cx lamp_cy center_valid center_cx center_cy
// out     | out_valid / out_ready   | direct_* offset_* delta_*
// cfg     | cfg_valid / cfg_ready   | cfg_index cfg_data
//
// one item per cycle sustained while the output is taken; an accepted item passes through
// the input register at the accepting edge, eight lane stages, then the merge/output register
// the whole pipeline advances while the output register is empty or being taken
// a stalled output freezes every stage; in_ready drops only then
// rst_n is asynchronous; it clears out_valid and the pipeline flags and loads the default coefficients
// cfg writes are always taken; lanes read the registers at several stages,
// so writes belong between items with the pipeline empty

`include "pixel_offset_to_distance_poly_assert.svh"

module pixel_offset_to_distance_poly #(
    parameter int PIXEL_WIDTH = 16,
    parameter int COEF_WIDTH = 24
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    lamp_valid,
    input  logic signed [PIXEL_WIDTH-1:0]           lamp_cx,
    input  logic signed [PIXEL_WIDTH-1:0]           lamp_cy,
    input  logic                                    center_valid,
    input  logic signed [PIXEL_WIDTH-1:0]           center_cx,
    input  logic signed [PIXEL_WIDTH-1:0]           center_cy,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    direct_valid,
    output logic signed [pod_pkg::DIST_W-1:0]       direct_x,
    output logic signed [pod_pkg::DIST_W-1:0]       direct_y,
    output logic                                    offset_valid,
    output logic signed [pod_pkg::OFFS_W-1:0]       offset_x,
    output logic signed [pod_pkg::OFFS_W-1:0]       offset_y,
    output logic                                    delta_valid,
    output logic signed [pod_pkg::DIST_W-1:0]       delta_x,
    output logic signed [pod_pkg::DIST_W-1:0]       delta_y,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pod_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [COEF_WIDTH-1:0]                   cfg_data
);

    // lanes run one bit wider than the pixel fields so the difference never wraps
    localparam int LW = PIXEL_WIDTH + 1;
    localparam int CW = COEF_WIDTH;
    localparam int LAT = pod_pkg::LANE_LAT;

    logic en;

    // config registers
    logic signed [CW-1:0]             x_lin_reg, x_cub_reg, x_qui_reg;
    logic signed [CW-1:0]             y_lin_reg, y_cub_reg, y_qui_reg;
    logic [pod_pkg::LIMIT_W-1:0]      limit_reg;
    logic                             cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lin_reg <= CW'(pod_pkg::X_LIN_RST);
            x_cub_reg <= CW'(pod_pkg::X_CUBIC_RST);
            x_qui_reg <= CW'(pod_pkg::X_QUINTIC_RST);
            y_lin_reg <= CW'(pod_pkg::Y_LIN_RST);
            y_cub_reg <= CW'(pod_pkg::Y_CUBIC_RST);
            y_qui_reg <= CW'(pod_pkg::Y_QUINTIC_RST);
            limit_reg <= pod_pkg::LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pod_pkg::IDX_X_LIN:     x_lin_reg <= cfg_data;
                pod_pkg::IDX_X_CUBIC:   x_cub_reg <= cfg_data;
                pod_pkg::IDX_X_QUINTIC: x_qui_reg <= cfg_data;
                pod_pkg::IDX_Y_LIN:     y_lin_reg <= cfg_data;
                pod_pkg::IDX_Y_CUBIC:   y_cub_reg <= cfg_data;
                pod_pkg::IDX_Y_QUINTIC: y_qui_reg <= cfg_data;
                pod_pkg::IDX_LIMIT:     limit_reg <= cfg_data[pod_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: output register free or being drained
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // input register, with the exact pixel difference formed here
    logic signed [LW-1:0] lx_reg, ly_reg, cx_reg, cy_reg, dx_reg, dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx_reg <= LW'(lamp_cx);
            ly_reg <= LW'(lamp_cy);
            cx_reg <= LW'(center_cx);
            cy_reg <= LW'(center_cy);
            dx_reg <= LW'(lamp_cx) - LW'(center_cx);
            dy_reg <= LW'(lamp_cy) - LW'(center_cy);
        end
    end

    // flags ride alongside the lanes, one entry per stage
    pod_pkg::flag_t flag_reg [LAT+1];
    pod_pkg::flag_t flag_in;

    assign flag_in.vld = in_valid;
    assign flag_in.lamp_ok = lamp_valid;
    assign flag_in.center_ok = center_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAT; i++)
            begin
                flag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            flag_reg[0] <= flag_in;
            for (int i = 1; i <= LAT; i++)
            begin
                flag_reg[i] <= flag_reg[i-1];
            end
        end
    end

    // six polynomial lanes: lamp, centre and difference on each axis
    logic signed [pod_pkg::DIST_W-1:0] lmx, lmy, cmx, cmy, dmx, dmy;

    pod_lane #(.PW(LW), .CW(CW)) u_lane_lx (
        .clk(clk), .en(en), .p(lx_reg),
        .c1(x_lin_reg), .c3(x_cub_reg), .c5(x_qui_reg), .lim(limit_reg), .d(lmx)
    );
    pod_lane #(.PW(LW), .CW(CW)) u_lane_ly (
        .clk(clk), .en(en), .p(ly_reg),
        .c1(y_lin_reg), .c3(y_cub_reg), .c5(y_qui_reg), .lim(limit_reg), .d(lmy)
    );
    pod_lane #(.PW(LW), .CW(CW)) u_lane_cx (
        .clk(clk), .en(en), .p(cx_reg),
        .c1(x_lin_reg), .c3(x_cub_reg), .c5(x_qui_reg), .lim(limit_reg), .d(cmx)
    );
    pod_lane #(.PW(LW), .CW(CW)) u_lane_cy (
        .clk(clk), .en(en), .p(cy_reg),
        .c1(y_lin_reg), .c3(y_cub_reg), .c5(y_qui_reg), .lim(limit_reg), .d(cmy)
    );
    pod_lane #(.PW(LW), .CW(CW)) u_lane_dx (
        .clk(clk), .en(en), .p(dx_reg),
        .c1(x_lin_reg), .c3(x_cub_reg), .c5(x_qui_reg), .lim(limit_reg), .d(dmx)
    );
    pod_lane #(.PW(LW), .CW(CW)) u_lane_dy (
        .clk(clk), .en(en), .p(dy_reg),
        .c1(y_lin_reg), .c3(y_cub_reg), .c5(y_qui_reg), .lim(limit_reg), .d(dmy)
    );

    // merge: offset subtraction, zeroing of invalid parts, output register
    pod_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .flg          (flag_reg[LAT]),
        .lmx          (lmx),
        .lmy          (lmy),
        .cmx          (cmx),
        .cmy          (cmy),
        .dmx          (dmx),
        .dmy          (dmy),
        .out_valid    (out_valid),
        .direct_valid (direct_valid),
        .direct_x     (direct_x),
        .direct_y     (direct_y),
        .offset_valid (offset_valid),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .delta_valid  (delta_valid),
        .delta_x      (delta_x),
        .delta_y      (delta_y)
    );

    // a pair result never stands valid without the lamp
    `POD_ASSERT_IMPL(a_pair_needs_lamp, clk, rst_n, out_valid && offset_valid, direct_valid)
    // invalid parts carry zero coordinates
    `POD_ASSERT_IMPL(a_direct_zero, clk, rst_n, out_valid && !direct_valid,
        direct_x == 0 && direct_y == 0)
    `POD_ASSERT_IMPL(a_pair_zero, clk, rst_n, out_valid && !offset_valid,
        offset_x == 0 && offset_y == 0 && delta_x == 0 && delta_y == 0)
    // limit write lands in the clamp register
    `POD_ASSERT_NEXT(a_limit_write, clk, rst_n, cfg_we && cfg_index == pod_pkg::IDX_LIMIT,
        limit_reg == $past(cfg_data[pod_pkg::LIMIT_W-1:0]))

endmodule

// ===== rtl/core/pod_satmul.sv =====
`timescale 1ns / 1ps

module pod_satmul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic [AW-1:0]               a,
    input  logic [BW-1:0]               b,
    output logic [pod_pkg::SAT_W-1:0]   p
);

    localparam int PW = AW + BW;
    localparam int EW = PW + 64;
    localparam logic [63:0] CAP = 64'h2000_0000_0000_0000;

    logic [PW-1:0] full;
    logic          over;

    assign full = a * b;
    assign over = EW'(full) > EW'(CAP);
    assign p = over ? pod_pkg::SAT_W'(CAP) : pod_pkg::SAT_W'(full);

endmodule

// ===== rtl/core/pod_lane.sv =====
`timescale 1ns / 1ps

module pod_lane #(
    parameter int PW = 17,
    parameter int CW = 24
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [PW-1:0]            p,
    input  logic signed [CW-1:0]            c1,
    input  logic signed [CW-1:0]            c3,
    input  logic signed [CW-1:0]            c5,
    input  logic [pod_pkg::LIMIT_W-1:0]     lim,
    output logic signed [pod_pkg::DIST_W-1:0] d
);

    localparam int SW = pod_pkg::SAT_W;
    localparam int VW = PW + 4;
    localparam int SH = VW;
    localparam int RW = SH - 4;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / 25);
    localparam int UW = PW + 4;
    localparam int U2W = 2 * UW - pod_pkg::Q_SHIFT;
    localparam int P3W = U2W + UW;
    localparam int U3W = ((P3W > SW) ? SW : P3W) - pod_pkg::Q_SHIFT;
    localparam int P5W = U3W + U2W;
    localparam int U5W = ((P5W > SW) ? SW : P5W) - pod_pkg::Q_SHIFT;
    localparam logic [63:0] HALF = 64'd1 << (pod_pkg::ROUND_SHIFT - 1);

    // stage 1: magnitude and reciprocal product for m*12/25
    logic [PW-1:0]      m_1_reg;
    logic [VW+RW-1:0]   prod_1_reg;
    logic               neg_1_reg;
    logic [PW-1:0]      m_1_next;
    logic [VW-1:0]      v_1;

    assign m_1_next = p[PW-1] ? PW'(-p) : PW'(p);
    assign v_1 = (VW'(m_1_next) << 3) + (VW'(m_1_next) << 2);

    // stage 2: u = floor(m*512/25) = 20m + floor(12m/25)
    logic [UW-1:0]      u_2_reg;
    logic               neg_2_reg;
    logic [VW-1:0]      v_2;
    logic [VW-1:0]      q0_2;
    logic [VW-1:0]      rem_2;
    logic [UW-1:0]      u_2_next;

    assign v_2 = (VW'(m_1_reg) << 3) + (VW'(m_1_reg) << 2);
    assign q0_2 = VW'(prod_1_reg >> SH);
    assign rem_2 = v_2 - VW'(q0_2 * 5'd25);
    assign u_2_next = (UW'(m_1_reg) << 4) + (UW'(m_1_reg) << 2) + UW'(q0_2)
                    + UW'(rem_2 >= VW'(25));

    // coefficient magnitudes and signs
    logic [CW-1:0] c1_mag, c3_mag, c5_mag;
    assign c1_mag = c1[CW-1] ? CW'(-c1) : CW'(c1);
    assign c3_mag = c3[CW-1] ? CW'(-c3) : CW'(c3);
    assign c5_mag = c5[CW-1] ? CW'(-c5) : CW'(c5);

    // stage 3: u^2 and linear term
    logic [UW-1:0]      u_3_reg;
    logic [U2W-1:0]     u2_3_reg;
    logic [SW-1:0]      t1_3_reg;
    logic               neg_3_reg;
    logic [2*UW-1:0]    sq_3;
    logic [SW-1:0]      t1_3_next;

    assign sq_3 = u_2_reg * u_2_reg;

    pod_satmul #(.AW(CW), .BW(UW)) u_mul_t1 (
        .a (c1_mag),
        .b (u_2_reg),
        .p (t1_3_next)
    );

    // stage 4: u^3
    logic [U2W-1:0]     u2_4_reg;
    logic [U3W-1:0]     u3_4_reg;
    logic [SW-1:0]      t1_4_reg;
    logic               neg_4_reg;
    logic [SW-1:0]      p3_4;

    pod_satmul #(.AW(U2W), .BW(UW)) u_mul_u3 (
        .a (u2_3_reg),
        .b (u_3_reg),
        .p (p3_4)
    );

    // stage 5: u^5 and cubic term
    logic [U5W-1:0]     u5_5_reg;
    logic [SW-1:0]      t1_5_reg;
    logic [SW-1:0]      t3_5_reg;
    logic               neg_5_reg;
    logic [SW-1:0]      p5_5;
    logic [SW-1:0]      t3_5_next;

    pod_satmul #(.AW(U3W), .BW(U2W)) u_mul_u5 (
        .a (u3_4_reg),
        .b (u2_4_reg),
        .p (p5_5)
    );

    pod_satmul #(.AW(CW), .BW(U3W)) u_mul_t3 (
        .a (c3_mag),
        .b (u3_4_reg),
        .p (t3_5_next)
    );

    // stage 6: quintic term
    logic [SW-1:0]      t1_6_reg;
    logic [SW-1:0]      t3_6_reg;
    logic [SW-1:0]      t5_6_reg;
    logic               neg_6_reg;
    logic [SW-1:0]      t5_6_next;

    pod_satmul #(.AW(CW), .BW(U5W)) u_mul_t5 (
        .a (c5_mag),
        .b (u5_5_reg),
        .p (t5_6_next)
    );

    // stage 7: signed sum of the three terms
    logic signed [63:0] s_7_reg;
    logic               neg_7_reg;
    logic signed [63:0] s1_7, s3_7, s5_7;

    assign s1_7 = c1[CW-1] ? -$signed({2'b00, t1_6_reg}) : $signed({2'b00, t1_6_reg});
    assign s3_7 = c3[CW-1] ? -$signed({2'b00, t3_6_reg}) : $signed({2'b00, t3_6_reg});
    assign s5_7 = c5[CW-1] ? -$signed({2'b00, t5_6_reg}) : $signed({2'b00, t5_6_reg});

    // stage 8: round half away from zero, clamp, apply sign
    logic [pod_pkg::DIST_W-1:0] d_reg;
    logic [63:0]                smag_8;
    logic [39:0]                r_8;
    logic [pod_pkg::LIMIT_W-1:0] cl_8;
    logic [pod_pkg::DIST_W-1:0] pos_8;
    logic                       flip_8;

    assign smag_8 = s_7_reg[63] ? 64'(-s_7_reg) : 64'(s_7_reg);
    assign r_8 = 40'((smag_8 + HALF) >> pod_pkg::ROUND_SHIFT);
    assign cl_8 = (r_8 > 40'(lim)) ? lim : r_8[pod_pkg::LIMIT_W-1:0];
    assign pos_8 = {1'b0, cl_8};
    assign flip_8 = s_7_reg[63] ^ neg_7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_1_reg    <= m_1_next;
            prod_1_reg <= (VW+RW)'(v_1) * (VW+RW)'(RECIP);
            neg_1_reg  <= p[PW-1];

            u_2_reg    <= u_2_next;
            neg_2_reg  <= neg_1_reg;

            u_3_reg    <= u_2_reg;
            u2_3_reg   <= U2W'(sq_3 >> pod_pkg::Q_SHIFT);
            t1_3_reg   <= t1_3_next;
            neg_3_reg  <= neg_2_reg;

            u2_4_reg   <= u2_3_reg;
            u3_4_reg   <= U3W'(p3_4 >> pod_pkg::Q_SHIFT);
            t1_4_reg   <= t1_3_reg;
            neg_4_reg  <= neg_3_reg;

            u5_5_reg   <= U5W'(p5_5 >> pod_pkg::Q_SHIFT);
            t1_5_reg   <= t1_4_reg;
            t3_5_reg   <= t3_5_next;
            neg_5_reg  <= neg_4_reg;

            t1_6_reg   <= t1_5_reg;
            t3_6_reg   <= t3_5_reg;
            t5_6_reg   <= t5_6_next;
            neg_6_reg  <= neg_5_reg;

            s_7_reg    <= s1_7 + s3_7 + s5_7;
            neg_7_reg  <= neg_6_reg;

            d_reg      <= flip_8 ? -pos_8 : pos_8;
        end
    end

    assign d = $signed(d_reg);

endmodule

// ===== rtl/core/pod_merge.sv =====
`timescale 1ns / 1ps

module pod_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  pod_pkg::flag_t                      flg,
    input  logic signed [pod_pkg::DIST_W-1:0]   lmx,
    input  logic signed [pod_pkg::DIST_W-1:0]   lmy,
    input  logic signed [pod_pkg::DIST_W-1:0]   cmx,
    input  logic signed [pod_pkg::DIST_W-1:0]   cmy,
    input  logic signed [pod_pkg::DIST_W-1:0]   dmx,
    input  logic signed [pod_pkg::DIST_W-1:0]   dmy,
    output logic                                out_valid,
    output logic                                direct_valid,
    output logic signed [pod_pkg::DIST_W-1:0]   direct_x,
    output logic signed [pod_pkg::DIST_W-1:0]   direct_y,
    output logic                                offset_valid,
    output logic signed [pod_pkg::OFFS_W-1:0]   offset_x,
    output logic signed [pod_pkg::OFFS_W-1:0]   offset_y,
    output logic                                delta_valid,
    output logic signed [pod_pkg::DIST_W-1:0]   delta_x,
    output logic signed [pod_pkg::DIST_W-1:0]   delta_y
);

    localparam int DW = pod_pkg::DIST_W;
    localparam int OW = pod_pkg::OFFS_W;

    logic          out_valid_reg;
    logic          dv_reg, ov_reg;
    logic [DW-1:0] dx_reg, dy_reg, ex_reg, ey_reg;
    logic [OW-1:0] ox_reg, oy_reg;
    logic          both;
    logic signed [OW-1:0] ox_next, oy_next;

    assign both = flg.lamp_ok & flg.center_ok;
    assign ox_next = OW'(lmx) - OW'(cmx);
    assign oy_next = OW'(lmy) - OW'(cmy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= flg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg <= flg.lamp_ok;
            ov_reg <= both;
            dx_reg <= flg.lamp_ok ? DW'(lmx) : '0;
            dy_reg <= flg.lamp_ok ? DW'(lmy) : '0;
            ox_reg <= both ? OW'(ox_next) : '0;
            oy_reg <= both ? OW'(oy_next) : '0;
            ex_reg <= both ? DW'(dmx) : '0;
            ey_reg <= both ? DW'(dmy) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign direct_valid = dv_reg;
    assign direct_x     = $signed(dx_reg);
    assign direct_y     = $signed(dy_reg);
    assign offset_valid = ov_reg;
    assign offset_x     = $signed(ox_reg);
    assign offset_y     = $signed(oy_reg);
    assign delta_valid  = ov_reg;
    assign delta_x      = $signed(ex_reg);
    assign delta_y      = $signed(ey_reg);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pod_pkg::*;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;

    logic in_valid;
    logic in_ready;
    logic lamp_valid;
    logic signed [15:0] lamp_cx;
    logic signed [15:0] lamp_cy;
    logic center_valid;
    logic signed [15:0] center_cx;
    logic signed [15:0] center_cy;

    logic out_valid;
    logic out_ready;
    logic direct_valid;
    logic signed [DIST_W-1:0] direct_x;
    logic signed [DIST_W-1:0] direct_y;
    logic offset_valid;
    logic signed [OFFS_W-1:0] offset_x;
    logic signed [OFFS_W-1:0] offset_y;
    logic delta_valid;
    logic signed [DIST_W-1:0] delta_x;
    logic signed [DIST_W-1:0] delta_y;

    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [23:0] cfg_data;

    // one expected result: the three distance parts of an item
    typedef struct {
        logic direct_valid;
        logic signed [DIST_W-1:0] direct_x;
        logic signed [DIST_W-1:0] direct_y;
        logic offset_valid;
        logic signed [OFFS_W-1:0] offset_x;
        logic signed [OFFS_W-1:0] offset_y;
        logic delta_valid;
        logic signed [DIST_W-1:0] delta_x;
        logic signed [DIST_W-1:0] delta_y;
    } distance_t;

    distance_t pending_dist[$];

    // predictor copy of the coefficient registers, index 0 = x axis, 1 = y axis
    logic signed [23:0] lin_coef[2];
    logic signed [23:0] cubic_coef[2];
    logic signed [23:0] quintic_coef[2];
    logic [LIMIT_W-1:0] dist_limit;

    int mismatch_cnt;
    int hold_off_cycles;   // receiver hold-off requested by a test
    bit idle_on;           // random gaps on both sides when set

    localparam longint unsigned PROD_MAX = 64'd1 << 61;

    pixel_offset_to_distance_poly i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .lamp_valid   (lamp_valid),
        .lamp_cx      (lamp_cx),
        .lamp_cy      (lamp_cy),
        .center_valid (center_valid),
        .center_cx    (center_cx),
        .center_cy    (center_cy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .direct_valid (direct_valid),
        .direct_x     (direct_x),
        .direct_y     (direct_y),
        .offset_valid (offset_valid),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .delta_valid  (delta_valid),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // polynomial predictor
    // ------------------------------------------------------------------

    // unsigned product saturated at 2^61
    function automatic longint unsigned capped_mul(longint unsigned a, longint unsigned b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if (prod > {64'd0, PROD_MAX})
            return PROD_MAX;
        return prod[63:0];
    endfunction

    // signed coefficient times an unsigned power, magnitude capped
    function automatic longint signed coef_term(logic signed [23:0] c, longint unsigned pw);
        longint signed cs;
        longint unsigned mag;
        longint signed t;
        cs = c;
        mag = (cs < 0) ? longint'(-cs) : cs;
        t = longint'(capped_mul(mag, pw));
        return (cs < 0) ? -t : t;
    endfunction

    // pixel offset (1/64 px) to distance (1/256 cm) on one axis
    function automatic longint signed pixel_to_cm(longint signed p, int ax);
        longint unsigned m, u, u2, u3, u5;
        longint signed s, r, lim;
        m = (p < 0) ? longint'(-p) : p;
        u = (m * 512) / 25;
        u2 = capped_mul(u, u) >> Q_SHIFT;
        u3 = capped_mul(u2, u) >> Q_SHIFT;
        u5 = capped_mul(u3, u2) >> Q_SHIFT;
        s = coef_term(lin_coef[ax], u) + coef_term(cubic_coef[ax], u3)
            + coef_term(quintic_coef[ax], u5);
        // round half away from zero at 1/256 cm
        if (s >= 0)
            r = (s + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        else
            r = -((-s + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);
        lim = {48'd0, dist_limit};
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        // sign flip applies even when the polynomial itself went negative
        return (p < 0) ? -r : r;
    endfunction

    function automatic distance_t predict_distance(
        logic lv, logic signed [15:0] lx, logic signed [15:0] ly,
        logic cv, logic signed [15:0] cx, logic signed [15:0] cy);
        distance_t d;
        longint signed lmx, lmy, cmx, cmy;
        logic both;
        both = lv && cv;
        lmx = pixel_to_cm(lx, 0);
        lmy = pixel_to_cm(ly, 1);
        cmx = pixel_to_cm(cx, 0);
        cmy = pixel_to_cm(cy, 1);
        d.direct_valid = lv;
        d.direct_x = lv ? DIST_W'(lmx) : '0;
        d.direct_y = lv ? DIST_W'(lmy) : '0;
        d.offset_valid = both;
        d.offset_x = both ? OFFS_W'(lmx - cmx) : '0;
        d.offset_y = both ? OFFS_W'(lmy - cmy) : '0;
        d.delta_valid = both;
        // pixel difference taken exactly, no wrap
        d.delta_x = both ? DIST_W'(pixel_to_cm(longint'(lx) - longint'(cx), 0)) : '0;
        d.delta_y = both ? DIST_W'(pixel_to_cm(longint'(ly) - longint'(cy), 1)) : '0;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_item(logic lv, logic signed [15:0] lx, logic signed [15:0] ly,
                             logic cv, logic signed [15:0] cx, logic signed [15:0] cy);
        int gap;
        in_valid <= 1'b1;
        lamp_valid <= lv;
        lamp_cx <= lx;
        lamp_cy <= ly;
        center_valid <= cv;
        center_cx <= cx;
        center_cy <= cy;
        do
            @(posedge clk);
        while (!in_ready);
        pending_dist.push_back(predict_distance(lv, lx, ly, cv, cx, cy));
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // pixel value: mostly within the polynomial's working range, sometimes anything
    function automatic logic signed [15:0] rand_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(0, 4000) - 2000;
        if (r < 7)
            return $urandom_range(0, 12000) - 6000;
        return $urandom;
    endfunction

    task automatic send_random_item();
        send_item($urandom_range(0, 9) != 0, rand_pixel(), rand_pixel(),
                  $urandom_range(0, 9) != 0, rand_pixel(), rand_pixel());
    endtask

    // called at a falling edge; stops offering, waits until every expected
    // result has come, ends at a falling edge
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_dist.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // write one register with the pipeline empty
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] value);
        wait_drained();
        repeat (12) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            IDX_X_LIN:     lin_coef[0] = value;
            IDX_X_CUBIC:   cubic_coef[0] = value;
            IDX_X_QUINTIC: quintic_coef[0] = value;
            IDX_Y_LIN:     lin_coef[1] = value;
            IDX_Y_CUBIC:   cubic_coef[1] = value;
            IDX_Y_QUINTIC: quintic_coef[1] = value;
            IDX_LIMIT:     dist_limit = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_coefs(int xl, int xc, int xq, int yl, int yc, int yq, int lim);
        write_reg(IDX_X_LIN, 24'(xl));
        write_reg(IDX_X_CUBIC, 24'(xc));
        write_reg(IDX_X_QUINTIC, 24'(xq));
        write_reg(IDX_Y_LIN, 24'(yl));
        write_reg(IDX_Y_CUBIC, 24'(yc));
        write_reg(IDX_Y_QUINTIC, 24'(yq));
        write_reg(IDX_LIMIT, 24'(lim));
    endtask

    // ------------------------------------------------------------------
    // receiver side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        out_ready = 1'b0;
        hold_off_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // result checker, against the oldest expectation
    always @(posedge clk)
    begin
        distance_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dist.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected item at %0t", $realtime);
            end
            else
            begin
                e = pending_dist.pop_front();
                if (e.direct_valid !== direct_valid || e.direct_x !== direct_x
                    || e.direct_y !== direct_y || e.offset_valid !== offset_valid
                    || e.offset_x !== offset_x || e.offset_y !== offset_y
                    || e.delta_valid !== delta_valid || e.delta_x !== delta_x
                    || e.delta_y !== delta_y)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch at %0t: exp %0b %0d %0d | %0b %0d %0d | %0b %0d %0d, got %0b %0d %0d | %0b %0d %0d | %0b %0d %0d",
                                 $realtime, e.direct_valid, e.direct_x, e.direct_y,
                                 e.offset_valid, e.offset_x, e.offset_y,
                                 e.delta_valid, e.delta_x, e.delta_y,
                                 direct_valid, direct_x, direct_y,
                                 offset_valid, offset_x, offset_y,
                                 delta_valid, delta_x, delta_y);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, valid flag combinations, widest pixel difference
    task automatic test_directed();
        idle_on = 1'b0;
        send_item(1, 0, 0, 1, 0, 0);
        send_item(1, 16'sh7fff, 16'sh7fff, 1, 16'sh7fff, 16'sh7fff);
        send_item(1, -16'sh8000, -16'sh8000, 1, -16'sh8000, -16'sh8000);
        send_item(1, 16'sh7fff, -16'sh8000, 1, -16'sh8000, 16'sh7fff);
        send_item(1, -16'sh8000, 16'sh7fff, 1, 16'sh7fff, -16'sh8000);
        send_item(0, 1234, -567, 1, 89, -10);
        send_item(1, 1234, -567, 0, 89, -10);
        send_item(0, -1, 1, 0, 1, -1);
        send_item(1, 1, -1, 1, -1, 1);
        send_item(1, 64, 640, 1, -64, -640);
        send_item(1, 3200, -3200, 1, 1600, 1600);
        send_item(1, 16'sh5555, 16'shaaaa, 1, 16'shaaaa, 16'sh5555);
        idle_on = 1'b1;
    endtask

    // a run of settings, extremes first, each followed by random items, then the defaults restored
    task automatic test_config_sweep();
        load_coefs(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 65535);
        repeat (50) send_random_item();
        load_coefs(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 65535);
        repeat (50) send_random_item();
        load_coefs(X_LIN_RST, X_CUBIC_RST, X_QUINTIC_RST, Y_LIN_RST, Y_CUBIC_RST,
                   Y_QUINTIC_RST, 0);
        repeat (30) send_random_item();
        // negative polynomial near zero, small limit
        load_coefs(-2792514, 0, 0, 0, -777111, 0, 1000);
        repeat (50) send_random_item();
        repeat (4)
        begin
            load_coefs($urandom_range(0, 16777215) - 8388608,
                       $urandom_range(0, 16777215) - 8388608,
                       $urandom_range(0, 16777215) - 8388608,
                       $urandom_range(0, 16777215) - 8388608,
                       $urandom_range(0, 16777215) - 8388608,
                       $urandom_range(0, 16777215) - 8388608,
                       $urandom_range(0, 65535));
            repeat (50) send_random_item();
        end
        load_coefs(X_LIN_RST, X_CUBIC_RST, X_QUINTIC_RST, Y_LIN_RST, Y_CUBIC_RST,
                   Y_QUINTIC_RST, LIMIT_RST);
    endtask

    // receiver holds off while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_off_cycles = 60;
        repeat (40) send_random_item();
        idle_on = 1'b1;
        wait_drained();
        repeat (20) send_random_item();
    endtask

    task automatic test_random();
        int k;
        for (k = 0; k < 900; k++)
        begin
            // stretches without idling now and then
            if (k % 150 == 0)
                idle_on = (k % 300 != 0);
            send_random_item();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        lamp_valid = 1'b0;
        lamp_cx = '0;
        lamp_cy = '0;
        center_valid = 1'b0;
        center_cx = '0;
        center_cy = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_cnt = 0;
        idle_on = 1'b1;
        lin_coef[0] = X_LIN_RST;
        cubic_coef[0] = X_CUBIC_RST;
        quintic_coef[0] = X_QUINTIC_RST;
        lin_coef[1] = Y_LIN_RST;
        cubic_coef[1] = Y_CUBIC_RST;
        quintic_coef[1] = Y_QUINTIC_RST;
        dist_limit = LIMIT_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_config_sweep();
        test_random();

        wait_drained();
        repeat (20) @(posedge clk);
        k = pending_dist.size();
        if (mismatch_cnt == 0 && k == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pod_pkg.sv
rtl/core/pod_satmul.sv
rtl/core/pod_lane.sv
rtl/core/pod_merge.sv
rtl/core/pixel_offset_to_distance_poly.sv
sim/tb_top.sv
